// ----- sv/sdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_pkg
// shared widths, segment tables and register indexes of the drum transition
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int NUM_W       = 16;   // raw count width, two's complement
    localparam int CNT_W       = 14;   // clamped count width
    localparam int HOLD_W      = 16;
    localparam int SEG_W       = 7;
    localparam int POS_N       = 4;    // displayed places
    localparam int FRAME_N     = 4;
    localparam int DIGITS_DEF  = 4;

    // n / 10 == (n * 52429) >> 19 for every n below 43690
    localparam int          DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_RECIP = 16'd52429;

    localparam logic [CNT_W-1:0]  MAX_VALUE_RST  = 14'd9999;
    localparam logic [HOLD_W-1:0] FRAME_HOLD_RST = 16'd10;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    typedef logic [3:0]       t_digit;
    typedef logic [SEG_W-1:0] t_seg;
    typedef logic [1:0]       t_frame;

    localparam t_frame FRAME_OLD  = 2'd0;
    localparam t_frame FRAME_LAST = 2'd3;

    typedef enum logic [0:0] {
        CFG_MAX_VALUE  = 1'b0,
        CFG_FRAME_HOLD = 1'b1
    } t_cfg_idx;

    function automatic t_seg seg_digit(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // segment pattern shown while a place rolls up towards its new digit
    function automatic t_seg seg_roll_up(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 7'd98;
            4'd1:    s = 7'd2;
            4'd2:    s = 7'd97;
            4'd3:    s = 7'd67;
            4'd4:    s = 7'd3;
            4'd5:    s = 7'd67;
            4'd6:    s = 7'd99;
            4'd7:    s = 7'd2;
            4'd8:    s = 7'd99;
            4'd9:    s = 7'd67;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sdt_place.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_place
// one pipeline stage that peels decimal place PLACE off both counts
// ----------------------------------------------------------------------------
module sdt_place
    import sdt_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF,
    parameter int PLACE  = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [CNT_W-1:0]             i_from_n,
    input  wire logic [CNT_W-1:0]             i_to_n,
    input  wire logic [DIGITS-1:0][3:0]       i_from_d,
    input  wire logic [DIGITS-1:0][3:0]       i_to_d,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [CNT_W-1:0]                  o_from_n,
    output logic [CNT_W-1:0]                  o_to_n,
    output logic [DIGITS-1:0][3:0]            o_from_d,
    output logic [DIGITS-1:0][3:0]            o_to_d
);

    localparam int PROD_W = CNT_W + 16;

    logic                    r_valid;
    logic [CNT_W-1:0]        r_from_n, r_to_n;
    logic [DIGITS-1:0][3:0]  r_from_d, r_to_d;

    logic [PROD_W-1:0]       w_from_p, w_to_p;
    logic [CNT_W-1:0]        w_from_q, w_to_q;
    logic [CNT_W-1:0]        w_from_r, w_to_r;
    logic [DIGITS-1:0][3:0]  n_from_d, n_to_d;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_from_p = PROD_W'(i_from_n) * PROD_W'(DIV10_RECIP);
        w_to_p   = PROD_W'(i_to_n) * PROD_W'(DIV10_RECIP);
        w_from_q = CNT_W'(w_from_p >> DIV10_SHIFT);
        w_to_q   = CNT_W'(w_to_p >> DIV10_SHIFT);
        w_from_r = i_from_n - CNT_W'(w_from_q * CNT_W'(10));
        w_to_r   = i_to_n - CNT_W'(w_to_q * CNT_W'(10));
        n_from_d = i_from_d;
        n_to_d   = i_to_d;
        n_from_d[PLACE] = w_from_r[3:0];
        n_to_d[PLACE]   = w_to_r[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_from_n <= w_from_q;
            r_to_n   <= w_to_q;
            r_from_d <= n_from_d;
            r_to_d   <= n_to_d;
        end
    end

    assign o_valid  = r_valid;
    assign o_from_n = r_from_n;
    assign o_to_n   = r_to_n;
    assign o_from_d = r_from_d;
    assign o_to_d   = r_to_d;

endmodule
`default_nettype wire

// ----- sv/sdt_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_frame
// builds the four animation frames and plays them out one per transaction
// ----------------------------------------------------------------------------
module sdt_frame
    import sdt_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [DIGITS-1:0][3:0]  i_from_d,
    input  wire logic [DIGITS-1:0][3:0]  i_to_d,
    input  wire logic [HOLD_W-1:0]       i_frame_hold,
    output logic                         o_tvalid,
    input  wire logic                    i_tready,
    output logic [47:0]                  o_tdata,
    output t_frame                       o_tuser,
    output logic                         o_tlast
);

    localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    function automatic logic [PW-1:0] top_place(input logic [DIGITS-1:0][3:0] d);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 1; i < DIGITS; i++) begin
            if (d[i] != 4'd0) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    logic [PW-1:0]                       w_fs, w_ts, w_start;
    logic [FRAME_N-1:0][POS_N-1:0][6:0]  n_code;
    logic [FRAME_N-1:0][POS_N-1:0]       n_mask;

    // classify stage
    logic                                r_va;
    logic [FRAME_N-1:0][POS_N-1:0][6:0]  r_a_code;
    logic [FRAME_N-1:0][POS_N-1:0]       r_a_mask;

    // play-out stage
    logic                                r_vb;
    t_frame                              r_frame;
    logic [FRAME_N-1:0][POS_N-1:0][6:0]  r_b_code;
    logic [FRAME_N-1:0][POS_N-1:0]       r_b_mask;

    logic                                w_xfer, w_take;
    logic [HOLD_W-1:0]                   w_hold;

    assign w_fs    = top_place(i_from_d);
    assign w_ts    = top_place(i_to_d);
    assign w_start = (w_fs > w_ts) ? w_fs : w_ts;

    for (genvar p = 0; p < POS_N; p++) begin : g_pos
        if (p < DIGITS) begin : g_lit
            logic fv, tv, chg;
            t_seg oc, nc;
            assign fv  = int'(w_fs) >= p;
            assign tv  = int'(w_ts) >= p;
            assign chg = (fv != tv) || (fv && tv && (i_from_d[p] != i_to_d[p]));
            assign oc  = fv ? seg_digit(i_from_d[p]) : SEG_BLANK;
            assign nc  = tv ? seg_digit(i_to_d[p]) : SEG_BLANK;

            assign n_code[0][p] = oc;
            assign n_code[1][p] = chg ? SEG_BLANK : oc;
            assign n_code[2][p] = !chg ? nc :
                                  (tv ? seg_roll_up(i_to_d[p]) : SEG_BLANK);
            assign n_code[3][p] = nc;

            for (genvar f = 0; f < FRAME_N; f++) begin : g_msk
                assign n_mask[f][p] = (int'(w_start) >= p) && (n_code[f][p] != SEG_BLANK);
            end
        end else begin : g_off
            for (genvar f = 0; f < FRAME_N; f++) begin : g_blk
                assign n_code[f][p] = SEG_BLANK;
                assign n_mask[f][p] = 1'b0;
            end
        end
    end

    assign w_xfer  = r_vb && i_tready;
    assign w_take  = !r_vb || (w_xfer && (r_frame == FRAME_LAST));
    assign o_ready = !r_va || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (o_ready) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_a_code <= n_code;
            r_a_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb    <= 1'b0;
            r_frame <= FRAME_OLD;
        end else if (w_take) begin
            r_vb    <= r_va;
            r_frame <= FRAME_OLD;
        end else if (w_xfer) begin
            r_frame <= r_frame + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_b_code <= r_a_code;
            r_b_mask <= r_a_mask;
        end
    end

    assign w_hold = (i_frame_hold == '0) ? HOLD_W'(1) : i_frame_hold;

    assign o_tvalid = r_vb;
    assign o_tdata  = {w_hold, r_b_mask[r_frame], r_b_code[r_frame][3],
                       r_b_code[r_frame][2], r_b_code[r_frame][1], r_b_code[r_frame][0]};
    assign o_tuser  = r_frame;
    assign o_tlast  = (r_frame == FRAME_LAST);

    a_idle_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vb |-> (r_frame == FRAME_OLD))
        else $error("frame counter moved with no item held");

    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && !i_tready) |=> $stable(r_frame))
        else $error("frame counter moved without a transaction");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && o_tlast) |=> (!o_tvalid || (o_tuser == FRAME_OLD)))
        else $error("next item did not start at the old-digits frame");

    a_mask_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tdata[28]) |-> (o_tdata[6:0] != SEG_BLANK))
        else $error("ones place lit with a blank code");

endmodule
`default_nettype wire

// ----- sv/seven_segment_drum_transition.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_drum_transition
// four-place seven-segment drum roll between an old and a new count
// ----------------------------------------------------------------------------
// Each input transaction carries an old and a new count; both are clamped to
// 0..max_value and split into decimal places, one place per pipeline stage.
// When the clamped counts differ the block emits four frames (old digits,
// changed places blanked, changed places rolling up, new digits), the last
// one flagged by tlast; equal counts give no output. One frame leaves per
// cycle while m_axis_tready is high, and the frame play-out register takes
// the next item only as the last frame of the current one is accepted. An
// item passes the clamp, place, classify and play-out registers in turn.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_drum_transition
    import sdt_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // from_number[15:0], to_number[31:16]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // ones[6:0], tens[13:7], hundreds[20:14], thousands[27:21],
    // visible_mask[31:28], hold_frames[47:32]
    output logic [47:0]        m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // frame_index[1:0]
    output logic               m_axis_tlast,   // last_frame
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_addr,
    input  wire logic [15:0]   i_cfg_wdata
);

    logic [CNT_W-1:0]   r_max_value;
    logic [HOLD_W-1:0]  r_frame_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value  <= MAX_VALUE_RST;
            r_frame_hold <= FRAME_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_VALUE:  r_max_value  <= i_cfg_wdata[CNT_W-1:0];
                CFG_FRAME_HOLD: r_frame_hold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    function automatic logic [CNT_W-1:0] clamp_count(input logic [NUM_W-1:0] v,
                                                     input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] c;
        if (v[NUM_W-1]) begin
            c = '0;
        end else if (v[NUM_W-2:0] > (NUM_W-1)'(lim)) begin
            c = lim;
        end else begin
            c = v[CNT_W-1:0];
        end
        return c;
    endfunction

    // clamp stage
    logic               r_v0;
    logic [CNT_W-1:0]   r_from0, r_to0;
    logic [CNT_W-1:0]   n_from0, n_to0;
    logic               w_ready0;

    // place stages, index 0 is the clamp stage output
    logic               w_valid [DIGITS+1];
    logic               w_ready [DIGITS+1];
    logic [CNT_W-1:0]   w_from_n [DIGITS+1];
    logic [CNT_W-1:0]   w_to_n [DIGITS+1];
    logic [DIGITS-1:0][3:0] w_from_d [DIGITS+1];
    logic [DIGITS-1:0][3:0] w_to_d [DIGITS+1];

    assign n_from0 = clamp_count(s_axis_tdata[15:0], r_max_value);
    assign n_to0   = clamp_count(s_axis_tdata[31:16], r_max_value);

    assign w_ready0      = !r_v0 || w_ready[0];
    assign s_axis_tready = w_ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_ready0) begin
            // equal counts give no frames, so drop them here
            r_v0 <= s_axis_tvalid && (n_from0 != n_to0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready0) begin
            r_from0 <= n_from0;
            r_to0   <= n_to0;
        end
    end

    assign w_valid[0]  = r_v0;
    assign w_from_n[0] = r_from0;
    assign w_to_n[0]   = r_to0;
    assign w_from_d[0] = '0;
    assign w_to_d[0]   = '0;

    for (genvar k = 0; k < DIGITS; k++) begin : g_place
        sdt_place #(
            .DIGITS (DIGITS),
            .PLACE  (k)
        ) u_place (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k]),
            .o_ready  (w_ready[k]),
            .i_from_n (w_from_n[k]),
            .i_to_n   (w_to_n[k]),
            .i_from_d (w_from_d[k]),
            .i_to_d   (w_to_d[k]),
            .o_valid  (w_valid[k+1]),
            .i_ready  (w_ready[k+1]),
            .o_from_n (w_from_n[k+1]),
            .o_to_n   (w_to_n[k+1]),
            .o_from_d (w_from_d[k+1]),
            .o_to_d   (w_to_d[k+1])
        );
    end

    sdt_frame #(
        .DIGITS (DIGITS)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[DIGITS]),
        .o_ready      (w_ready[DIGITS]),
        .i_from_d     (w_from_d[DIGITS]),
        .i_to_d       (w_to_d[DIGITS]),
        .i_frame_hold (r_frame_hold),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser),
        .o_tlast      (m_axis_tlast)
    );

endmodule
`default_nettype wire
